>>> design/longest_remaining_time_scheduler_unit_macros.svh
// assertion macros for the longest-remaining-time scheduler
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define LRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define LRTS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> design/lrts_pkg.sv
// shared constants and types of the longest-remaining-time scheduler
// no dependencies
package lrts_pkg;

  // table size and derived widths
  localparam int unsigned MaxJobs = 16;
  localparam int unsigned IdxW    = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CntW    = $clog2(MaxJobs + 1);

  // field widths
  localparam int unsigned ClkW    = 20;
  localparam int unsigned RemW    = 16;
  localparam int unsigned JobNumW = 5;
  localparam int unsigned KindW   = 2;

  localparam logic [ClkW-1:0] ClockMax = '1;

  // input operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_RAN      = 2'd1,
    KIND_IDLE     = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  // best-so-far candidate moving down the cell chain
  typedef struct packed {
    logic            found;
    logic [RemW-1:0] rem;
    logic [ClkW-1:0] arr;
    logic [IdxW-1:0] idx;
  } cand_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic            wr_en;
    logic            dec_en;
    logic [IdxW-1:0] slot;
    logic [RemW-1:0] rem;
    logic [ClkW-1:0] arr;
  } cmd_t;

endpackage

>>> design/lrts_cell.sv
// one job slot of the scheduler chain: holds remaining and arrival time
// and passes the better of its job and the incoming candidate on; uses lrts_pkg
module lrts_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lrts_pkg::IdxW-1:0] slot_i,
  input  logic [lrts_pkg::CntW-1:0] loaded_cnt_i,
  input  logic [lrts_pkg::ClkW-1:0] clock_i,
  input  lrts_pkg::cmd_t            cmd_i,
  input  lrts_pkg::cand_t           cand_i,
  output lrts_pkg::cand_t           cand_o
);

  logic [lrts_pkg::RemW-1:0] rem_q, rem_d;
  logic [lrts_pkg::ClkW-1:0] arr_q, arr_d;
  lrts_pkg::cand_t           cand_q, cand_d;
  logic                      loaded, eligible, take, hit;

  // slot contents: load on add, count down when run
  assign hit = (cmd_i.slot == slot_i);

  always_comb begin
    rem_d = rem_q;
    arr_d = arr_q;
    if (cmd_i.wr_en && hit) begin
      rem_d = cmd_i.rem;
      arr_d = cmd_i.arr;
    end else if (cmd_i.dec_en && hit) begin
      rem_d = rem_q - lrts_pkg::RemW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    arr_q <= arr_d;
  end

  // compare own job with the candidate, strict greater keeps the lower slot on ties
  assign loaded   = (lrts_pkg::CntW'(slot_i) < loaded_cnt_i);
  assign eligible = loaded && (rem_q != '0) && (arr_q <= clock_i);
  assign take     = eligible && (!cand_i.found || (rem_q > cand_i.rem));

  always_comb begin
    cand_d = cand_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.rem   = rem_q;
      cand_d.arr   = arr_q;
      cand_d.idx   = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

>>> design/longest_remaining_time_scheduler_unit.sv
// top level of the longest-remaining-time-first scheduler
// uses lrts_pkg, lrts_cell and the assertion macro header
//
// Input stream: one beat per command. tuser selects the command (0 = add a
// job, 1 = tick one time unit); tdata carries arrival and burst time of an
// added job. Output stream: exactly one result beat per input beat, in order;
// tuser gives the result kind (accepted, ran, idle, full).
// Job slots sit in a row of cells. A tick sends an empty candidate down the
// row, one cell per cycle, each cell keeping the larger remaining time, so a
// tick runs through the scan state over all MaxJobs cells and then commits
// in the done state; an add goes from accept straight to the done state and
// commits there. Both give their result from the output register. One command
// is in work at a time; the next is taken once the previous result is parked
// in the output register, so a stalled receiver holds the result and blocks
// at most one further command at commit.
// Reset empties the job table and zeroes the scheduler clock; no clearing
// pass is needed.
`include "longest_remaining_time_scheduler_unit_macros.svh"

module longest_remaining_time_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [19:0] arrival_time, [35:20] burst_time, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] job_number, [5] job_finished, [25:6] completion_time,
  // [45:26] turnaround_time, [65:46] clock_now, [71:66] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]  m_axis_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [lrts_pkg::IdxW-1:0]     cnt_q, cnt_d;
  logic [lrts_pkg::CntW-1:0]     loaded_q, loaded_d;
  logic [lrts_pkg::ClkW-1:0]     clock_q, clock_d, clock_next;
  logic                          op_q;
  logic [lrts_pkg::ClkW-1:0]     in_arr_q;
  logic [lrts_pkg::RemW-1:0]     in_rem_q;
  logic                          in_beat, commit, out_free;
  lrts_pkg::cmd_t                cmd;
  lrts_pkg::cand_t               cand_w [lrts_pkg::MaxJobs+1];
  lrts_pkg::cand_t               best;

  // result fields
  lrts_pkg::kind_e               kind_d, kind_q;
  logic [lrts_pkg::JobNumW-1:0]  num_d, num_q;
  logic                          fin_d, fin_q;
  logic [lrts_pkg::ClkW-1:0]     comp_d, comp_q, turn_d, turn_q, now_q;
  logic                          m_valid_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == ST_DONE) && out_free;

  // command latch
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q     <= s_axis_tuser[0];
      in_arr_q <= s_axis_tdata[19:0];
      in_rem_q <= s_axis_tdata[35:20];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_beat) begin
          state_d = (s_axis_tuser[0] == lrts_pkg::OP_TICK) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + lrts_pkg::IdxW'(1);
        if (cnt_q == lrts_pkg::IdxW'(lrts_pkg::MaxJobs - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // row of job cells, an empty candidate enters at the head
  assign cand_w[0] = '0;

  for (genvar g = 0; g < lrts_pkg::MaxJobs; g++) begin : g_cell
    lrts_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .slot_i       (lrts_pkg::IdxW'(g)),
      .loaded_cnt_i (loaded_q),
      .clock_i      (clock_q),
      .cmd_i        (cmd),
      .cand_i       (cand_w[g]),
      .cand_o       (cand_w[g+1])
    );
  end

  assign best       = cand_w[lrts_pkg::MaxJobs];
  assign clock_next = (clock_q == lrts_pkg::ClockMax) ? clock_q
                                                      : clock_q + lrts_pkg::ClkW'(1);

  // commit: state update and result
  always_comb begin
    cmd      = '0;
    loaded_d = loaded_q;
    clock_d  = clock_q;
    kind_d   = lrts_pkg::KIND_IDLE;
    num_d    = '0;
    fin_d    = 1'b0;
    comp_d   = '0;
    turn_d   = '0;
    if (op_q == lrts_pkg::OP_ADD) begin
      if (loaded_q < lrts_pkg::CntW'(lrts_pkg::MaxJobs)) begin
        cmd.wr_en = commit;
        cmd.slot  = loaded_q[lrts_pkg::IdxW-1:0];
        cmd.rem   = in_rem_q;
        cmd.arr   = in_arr_q;
        loaded_d  = loaded_q + lrts_pkg::CntW'(1);
        kind_d    = lrts_pkg::KIND_ACCEPTED;
        num_d     = lrts_pkg::JobNumW'(loaded_q) + lrts_pkg::JobNumW'(1);
      end else begin
        kind_d = lrts_pkg::KIND_FULL;
      end
    end else begin
      clock_d = clock_next;
      if (best.found) begin
        cmd.dec_en = commit;
        cmd.slot   = best.idx;
        kind_d     = lrts_pkg::KIND_RAN;
        num_d      = lrts_pkg::JobNumW'(best.idx) + lrts_pkg::JobNumW'(1);
        if (best.rem == lrts_pkg::RemW'(1)) begin
          fin_d  = 1'b1;
          comp_d = clock_next;
          turn_d = clock_next - best.arr;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      loaded_q  <= '0;
      clock_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (commit) begin
        loaded_q  <= loaded_d;
        clock_q   <= clock_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      kind_q <= kind_d;
      num_q  <= num_d;
      fin_q  <= fin_d;
      comp_q <= comp_d;
      turn_q <= turn_d;
      now_q  <= clock_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {6'b0, now_q, turn_q, comp_q, fin_q, num_q};

  // checks
  `LRTS_ASSERT(a_beat_starts_work, in_beat |=> (state_q == ST_SCAN || state_q == ST_DONE), "accepted beat did not start work")
  `LRTS_ASSERT_NEVER(a_loaded_bound, loaded_q > lrts_pkg::CntW'(lrts_pkg::MaxJobs), "job count exceeds table size")
  `LRTS_ASSERT(a_clock_monotonic, clock_q >= $past(clock_q), "scheduler clock went backwards")
  `LRTS_ASSERT(a_ran_has_job, (m_axis_tvalid && m_axis_tuser == lrts_pkg::KIND_RAN) |-> (m_axis_tdata[4:0] != 5'd0), "run result without job number")

endmodule
